### design/cagn_pkg.sv
// Shared types, constants and helpers for the class-aware greedy NMS block.
// Used by the top, config and overlap files; depends on nothing.
`default_nettype none

package cagn_pkg;

  localparam int MAX_KEPT_DEF   = 64;
  localparam int CAND_DEPTH_DEF = 320;
  localparam int STORE_FACTOR   = 5;

  // Counter widths sized for the largest legal parameter values.
  localparam int LIMIT_W = 7;
  localparam int CNT_W   = 9;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_SCORE_THR   = 2'd0;
  localparam logic [1:0] REG_OVERLAP_THR = 2'd1;
  localparam logic [1:0] REG_MAX_DET     = 2'd2;

  localparam logic [15:0] SCORE_THR_RST   = 16'd16384;
  localparam logic [15:0] OVERLAP_THR_RST = 16'd29491;
  localparam logic [6:0]  MAX_DET_RST     = 7'd64;

  typedef struct packed {
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } box_t;

  typedef struct packed {
    logic        supp;
    logic [15:0] score;
    logic [7:0]  cls;
    box_t        box;
  } cand_t;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [15:0]        score;
    logic [7:0]         class_id;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [15:0]        kept_score;
    logic [7:0]         kept_class;
    logic               empty_frame;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        score_thr;
    logic [15:0]        overlap_thr;
    logic [LIMIT_W-1:0] limit;
    logic [CNT_W-1:0]   cap;
  } cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/cagn_stream_if.sv
// Valid/ready stream channel carrying one packed payload.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface cagn_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/class_aware_greedy_nms_top.sv
// Class-aware greedy NMS: channel  | dir | handshake   | payload
//                          cand    | in  | valid/ready | in_item_t (one candidate box)
//                          det     | out | valid/ready | out_item_t (kept box or empty marker)
//                          APB     | in  | psel/penable| three config registers
// A dropped request passes through the score check and the frame-end check; an insertion
// shifts lower-scored store entries down one place each, and a full store first reads
// and checks its lowest entry. On frame end, the outer walk reads each stored candidate,
// the inner walk each later entry, and each same-class pair goes through the overlap
// pipeline; all through the single read port of the candidate RAM. A kept box
// waits for the result register to free up. The result register frees the input side
// while a result waits. Reset clears control only; the store needs no clearing pass.
`default_nettype none

module class_aware_greedy_nms_top
  import cagn_pkg::*;
#(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int CAND_DEPTH = CAND_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  cagn_stream_if.sink             cand,
  cagn_stream_if.source           det,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  localparam int AW = $clog2(CAND_DEPTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CONV   = 4'd1;
  localparam logic [3:0] S_FULLRD = 4'd2;
  localparam logic [3:0] S_FULLCK = 4'd3;
  localparam logic [3:0] S_SHRD   = 4'd4;
  localparam logic [3:0] S_SHWR   = 4'd5;
  localparam logic [3:0] S_FE     = 4'd6;
  localparam logic [3:0] S_ORD    = 4'd7;
  localparam logic [3:0] S_OCK    = 4'd8;
  localparam logic [3:0] S_KEEP   = 4'd9;
  localparam logic [3:0] S_AREA   = 4'd10;
  localparam logic [3:0] S_IRD    = 4'd11;
  localparam logic [3:0] S_ICK    = 4'd12;
  localparam logic [3:0] S_IWAIT  = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  cfg_t cfg;

  logic [3:0]         state;
  in_item_t           item;
  cand_t              newc;
  cand_t              cur;
  cand_t              pend;
  cand_t              bword;
  logic               pend_v;
  logic [CNT_W-1:0]   cnt, slot, i, j, n;
  logic [LIMIT_W-1:0] kept;
  logic [31:0]        area_a;
  logic               det_valid;
  out_item_t          det_data;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  cand_t              ram_wdata, rdata;

  logic [CNT_W-1:0]   cnt_clip, cap_m1, slot_m1, i_next, j_next;
  logic               out_free, go_on, cls_match, iou_start, iou_done, iou_hit;
  logic               det_load;
  logic [15:0]        wl, hl, wh, hh;
  cand_t              conv;
  logic signed [16:0] aw_s, ah_s;
  cand_t              supp_word;

  function automatic out_item_t make_out(input cand_t c, input logic last);
    out_item_t o;
    o.left        = c.box.left;
    o.top         = c.box.top;
    o.right       = c.box.right;
    o.bottom      = c.box.bottom;
    o.kept_score  = c.score;
    o.kept_class  = c.cls;
    o.empty_frame = 1'b0;
    o.last_result = last;
    return o;
  endfunction

  function automatic out_item_t make_empty();
    out_item_t o;
    o             = '0;
    o.empty_frame = 1'b1;
    o.last_result = 1'b1;
    return o;
  endfunction

  cagn_cfg #(
    .MAX_KEPT   (MAX_KEPT),
    .CAND_DEPTH (CAND_DEPTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cagn_ram #(
    .WIDTH ($bits(cand_t)),
    .DEPTH (CAND_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  cagn_iou u_iou (
    .clk    (clk),
    .rst    (rst),
    .start  (iou_start),
    .a      (cur.box),
    .area_a (area_a),
    .b      (rdata.box),
    .thr    (cfg.overlap_thr),
    .done   (iou_done),
    .hit    (iou_hit)
  );

  assign cand.ready  = (state == S_IDLE);
  assign det.valid   = det_valid;
  assign det.payload = det_data;

  always_comb begin
    cnt_clip  = (cnt > cfg.cap) ? cfg.cap : cnt;
    cap_m1    = cfg.cap - 1'b1;
    slot_m1   = slot - 1'b1;
    i_next    = i + 1'b1;
    j_next    = j + 1'b1;
    out_free  = !det_valid || det.ready;
    det_load  = ((state == S_KEEP) && pend_v && out_free) || ((state == S_FIN) && out_free);
    go_on     = (i < n) && (kept < cfg.limit);
    cls_match = !rdata.supp && (rdata.cls == cur.cls);
    iou_start = (state == S_ICK) && cls_match;
    supp_word = bword;
    supp_word.supp = 1'b1;

    // Box corners: the lower half of the size goes left/up, the rest right/down.
    wl = {1'b0, item.box_width[15:1]};
    hl = {1'b0, item.box_height[15:1]};
    wh = item.box_width - wl;
    hh = item.box_height - hl;
    conv.supp       = 1'b0;
    conv.score      = item.score;
    conv.cls        = item.class_id;
    conv.box.left   = sat16({{2{item.center_x[15]}}, item.center_x} - {2'b00, wl});
    conv.box.top    = sat16({{2{item.center_y[15]}}, item.center_y} - {2'b00, hl});
    conv.box.right  = sat16({{2{item.center_x[15]}}, item.center_x} + {2'b00, wh});
    conv.box.bottom = sat16({{2{item.center_y[15]}}, item.center_y} + {2'b00, hh});

    aw_s = {cur.box.right[15], cur.box.right} - {cur.box.left[15], cur.box.left};
    ah_s = {cur.box.bottom[15], cur.box.bottom} - {cur.box.top[15], cur.box.top};
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot[AW-1:0];
    ram_wdata = newc;
    ram_re    = 1'b0;
    ram_raddr = i[AW-1:0];
    case (state)
      S_FULLRD: begin
        ram_re    = 1'b1;
        ram_raddr = cap_m1[AW-1:0];
      end
      S_SHRD: begin
        if (slot == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_m1[AW-1:0];
        end
      end
      S_SHWR: begin
        // Walking up from the free slot: either the new entry lands here or the
        // lower-scored neighbor above moves down one place.
        ram_we = 1'b1;
        if (rdata.score < newc.score) begin
          ram_wdata = rdata;
        end
      end
      S_ORD: begin
        ram_re = go_on;
      end
      S_IRD: begin
        ram_re    = (j < n);
        ram_raddr = j[AW-1:0];
      end
      S_IWAIT: begin
        ram_we    = iou_done && iou_hit;
        ram_waddr = j[AW-1:0];
        ram_wdata = supp_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend_v    <= 1'b0;
      det_valid <= 1'b0;
    end else begin
      if (det_load) begin
        det_valid <= 1'b1;
      end else if (det_valid && det.ready) begin
        det_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cand.valid) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (item.score > cfg.score_thr) begin
            if (cnt_clip < cfg.cap) begin
              slot  <= cnt_clip;
              cnt   <= cnt_clip + 1'b1;
              state <= S_SHRD;
            end else begin
              cnt   <= cnt_clip;
              state <= S_FULLRD;
            end
          end else begin
            state <= S_FE;
          end
        end
        S_FULLRD: state <= S_FULLCK;
        S_FULLCK: begin
          // A full store takes the new entry only if it beats the lowest one.
          if (rdata.score >= newc.score) begin
            state <= S_FE;
          end else begin
            slot  <= cap_m1;
            state <= S_SHRD;
          end
        end
        S_SHRD: begin
          state <= (slot == '0) ? S_FE : S_SHWR;
        end
        S_SHWR: begin
          if (rdata.score >= newc.score) begin
            state <= S_FE;
          end else begin
            slot  <= slot_m1;
            state <= S_SHRD;
          end
        end
        S_FE: begin
          if (item.frame_end) begin
            n      <= cnt_clip;
            i      <= '0;
            kept   <= '0;
            pend_v <= 1'b0;
            state  <= S_ORD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ORD: begin
          state <= go_on ? S_OCK : S_FIN;
        end
        S_OCK: begin
          if (rdata.supp) begin
            i     <= i_next;
            state <= S_ORD;
          end else begin
            cur   <= rdata;
            kept  <= kept + 1'b1;
            state <= S_KEEP;
          end
        end
        S_KEEP: begin
          // The previous kept box goes out only now that it is known not to be last.
          if (!pend_v || out_free) begin
            if (pend_v) begin
              det_data <= make_out(pend, 1'b0);
            end
            pend   <= cur;
            pend_v <= 1'b1;
            state  <= (kept == cfg.limit) ? S_ORD : S_AREA;
          end
        end
        S_AREA: begin
          area_a <= aw_s[15:0] * ah_s[15:0];
          j      <= i_next;
          state  <= S_IRD;
        end
        S_IRD: begin
          if (j < n) begin
            state <= S_ICK;
          end else begin
            i     <= i_next;
            state <= S_ORD;
          end
        end
        S_ICK: begin
          bword <= rdata;
          if (cls_match) begin
            state <= S_IWAIT;
          end else begin
            j     <= j_next;
            state <= S_IRD;
          end
        end
        S_IWAIT: begin
          if (iou_done) begin
            j     <= j_next;
            state <= S_IRD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            det_data <= pend_v ? make_out(pend, 1'b1) : make_empty();
            pend_v   <= 1'b0;
            cnt      <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cand.valid) begin
      item <= cand.payload;
    end
    if (state == S_CONV) begin
      newc <= conv;
    end
  end

endmodule

`default_nettype wire

### design/cagn_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module cagn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/cagn_cfg.sv
// APB-style register file for thresholds and the detection limit, plus the
// derived limit and store capacity. Depends on cagn_pkg.
`default_nettype none

module cagn_cfg
  import cagn_pkg::*;
#(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int CAND_DEPTH = CAND_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  output      cfg_t               cfg
);

  logic [15:0]      score_thr;
  logic [15:0]      overlap_thr;
  logic [6:0]       max_det;
  logic [1:0]       reg_idx;
  logic [LIMIT_W-1:0] lim;
  logic [CNT_W+2:0] cap_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr   <= SCORE_THR_RST;
      overlap_thr <= OVERLAP_THR_RST;
      max_det     <= MAX_DET_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_SCORE_THR:   score_thr   <= pwdata[15:0];
        REG_OVERLAP_THR: overlap_thr <= pwdata[15:0];
        REG_MAX_DET:     max_det     <= pwdata[6:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCORE_THR:   prdata = {16'd0, score_thr};
      REG_OVERLAP_THR: prdata = {16'd0, overlap_thr};
      REG_MAX_DET:     prdata = {25'd0, max_det};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (max_det == 7'd0) begin
      lim = LIMIT_W'(1);
    end else if (int'(max_det) > MAX_KEPT) begin
      lim = LIMIT_W'(MAX_KEPT);
    end else begin
      lim = LIMIT_W'(max_det);
    end
    cap_full = (CNT_W+3)'(lim) * (CNT_W+3)'(STORE_FACTOR);
    cfg.score_thr   = score_thr;
    cfg.overlap_thr = overlap_thr;
    cfg.limit       = lim;
    if (int'(cap_full) > CAND_DEPTH) begin
      cfg.cap = CNT_W'(CAND_DEPTH);
    end else begin
      cfg.cap = cap_full[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

### design/cagn_iou.sv
// Four-stage overlap test: intersection * 2^16 > threshold * union, with a
// strictly positive intersection required. Depends on cagn_pkg.
`default_nettype none

module cagn_iou
  import cagn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire box_t        a,
  input  wire logic [31:0] area_a,
  input  wire box_t        b,
  input  wire logic [15:0] thr,
  output      logic        done,
  output      logic        hit
);

  logic signed [15:0] ix1, iy1, ix2, iy2;
  logic signed [16:0] dx, dy, bw, bh;
  logic        v1, v2, v3, v4;
  logic        pos1, pos2, pos3, pos4;
  logic [15:0] dx1, dy1, bw1, bh1;
  logic [31:0] inter2, areab2, inter3, inter4;
  logic [32:0] uni3;
  logic [48:0] prod4;

  always_comb begin
    ix1 = (a.left > b.left)     ? a.left   : b.left;
    iy1 = (a.top > b.top)       ? a.top    : b.top;
    ix2 = (a.right < b.right)   ? a.right  : b.right;
    iy2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    dx  = {ix2[15], ix2} - {ix1[15], ix1};
    dy  = {iy2[15], iy2} - {iy1[15], iy1};
    bw  = {b.right[15], b.right} - {b.left[15], b.left};
    bh  = {b.bottom[15], b.bottom} - {b.top[15], b.top};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    pos1   <= (dx > 17'sd0) && (dy > 17'sd0);
    dx1    <= dx[15:0];
    dy1    <= dy[15:0];
    bw1    <= bw[15:0];
    bh1    <= bh[15:0];
    pos2   <= pos1;
    inter2 <= dx1 * dy1;
    areab2 <= bw1 * bh1;
    pos3   <= pos2;
    inter3 <= inter2;
    uni3   <= {1'b0, area_a} + {1'b0, areab2} - {1'b0, inter2};
    pos4   <= pos3;
    inter4 <= inter3;
    prod4  <= thr * uni3;
  end

  assign done = v4;
  assign hit  = pos4 && ({1'b0, inter4, 16'd0} > prod4);

endmodule

`default_nettype wire
